@@ rtl/gmpst_pkg.sv @@
package gmpst_pkg;

    // Fixed field widths of the stream and register interfaces
    localparam int DIM_W      = 6;      // row / column numbers and size registers
    localparam int TOTAL_W    = 14;     // cell totals and best total
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int M_TDATA_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Defaults for the top level parameters
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_VALUE_BITS  = 8;

    // Register index, taken from the word address
    typedef enum logic {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } cfg_reg_t;

    // Result kind on m_tuser
    typedef enum logic {
        KIND_TOTAL = 1'b0,
        KIND_PATH  = 1'b1
    } result_kind_t;

    // One traced cell, 1-based
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } path_entry_t;

endpackage

@@ rtl/gmpst_total_ram.sv @@
module gmpst_total_ram
    import gmpst_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLUMNS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TOTAL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output logic [TOTAL_W-1:0] rd_data_a,
    output logic [TOTAL_W-1:0] rd_data_b
);

    logic [TOTAL_W-1:0] mem [DEPTH];
    logic [TOTAL_W-1:0] rd_data_a_reg;
    logic [TOTAL_W-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ rtl/gmpst_stack_ram.sv @@
module gmpst_stack_ram
    import gmpst_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_ROWS + DEF_MAX_COLUMNS - 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  path_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output path_entry_t       rd_data
);

    path_entry_t mem [DEPTH];
    path_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/grid_max_path_sum_traceback.sv @@
// Cell load: each cell transaction is accept + read of the total above, then sum + write.
// Last cell: traceback does, per path cell, a two-port read of the total table, then
// decide and push, for up to rows + columns - 1 path cells; results then leave as 1 total
// followed by the path cells, each read from the path stack and then loaded, held while m_tready is low.
// Reset (aresetn low, synchronous): sizes return to 1x1, the run restarts at cell 1,
// output channel empties. Total table and path stack are not cleared.
module grid_max_path_sum_traceback
    import gmpst_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // cell stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] cell_value

    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_TDATA_W-1:0]                m_tdata,   // best_total, path_row, path_column
    output logic                                m_tuser,   // result_kind
    output logic                                m_tlast,   // last_result

    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready
);

    localparam int TBL_DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int TBL_ADDR_W  = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int LIN_W       = TBL_ADDR_W + DIM_W;
    localparam int STK_DEPTH   = MAX_ROWS + MAX_COLUMNS - 1;
    localparam int STK_ADDR_W  = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int STK_CNT_W   = $clog2(STK_DEPTH + 1);
    localparam int SUM_W       = ((VALUE_BITS > TOTAL_W) ? VALUE_BITS : TOTAL_W) + 1;
    localparam int OUT_PAD_W   = M_TDATA_W - TOTAL_W - 2 * DIM_W;

    localparam logic [DIM_W-1:0] ROW_LIMIT = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COL_LIMIT = DIM_W'(MAX_COLUMNS);
    localparam logic [DIM_W-1:0] ONE_DIM   = DIM_W'(1);

    // Sequencer: cell load (IDLE/CALC), trace (TR_RD/TR_EV), emit (TOTAL/POP_RD/POP_LD)
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CALC   = 7'b0000010,
        S_TR_RD  = 7'b0000100,
        S_TR_EV  = 7'b0001000,
        S_TOTAL  = 7'b0010000,
        S_POP_RD = 7'b0100000,
        S_POP_LD = 7'b1000000
    } state_t;

    // Table address of a 1-based cell; row stride is MAX_COLUMNS
    function automatic logic [TBL_ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                                         input logic [DIM_W-1:0] col);
        logic [LIN_W-1:0] lin;
        lin = LIN_W'(row - ONE_DIM) * LIN_W'(MAX_COLUMNS) + LIN_W'(col - ONE_DIM);
        return lin[TBL_ADDR_W-1:0];
    endfunction

    // ---------------- registers ----------------
    state_t                 state_reg,     state_next;
    logic [DIM_W-1:0]       rows_reg,      rows_next;
    logic [DIM_W-1:0]       cols_reg,      cols_next;
    logic [DIM_W-1:0]       cur_row_reg,   cur_row_next;   // cell position of next transaction
    logic [DIM_W-1:0]       cur_col_reg,   cur_col_next;
    logic [STK_CNT_W-1:0]   depth_reg,     depth_next;     // entries on the path stack
    logic                   m_tvalid_reg,  m_tvalid_next;

    logic [VALUE_BITS-1:0]  value_reg,     value_next;
    logic [TOTAL_W-1:0]     left_reg,      left_next;      // total of previous cell
    logic [TOTAL_W-1:0]     best_reg,      best_next;
    logic [TOTAL_W-1:0]     here_reg,      here_next;      // total at trace position
    logic [DIM_W-1:0]       tr_row_reg,    tr_row_next;
    logic [DIM_W-1:0]       tr_col_reg,    tr_col_next;
    result_kind_t           out_kind_reg,  out_kind_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic [DIM_W-1:0]       out_row_reg,   out_row_next;
    logic [DIM_W-1:0]       out_col_reg,   out_col_next;
    logic                   out_last_reg,  out_last_next;

    // ---------------- memory ports ----------------
    logic                   tot_wr_en;
    logic [TBL_ADDR_W-1:0]  tot_wr_addr;
    logic [TOTAL_W-1:0]     tot_wr_data;
    logic                   tot_rd_en;
    logic [TBL_ADDR_W-1:0]  tot_rd_addr_a;
    logic [TBL_ADDR_W-1:0]  tot_rd_addr_b;
    logic [TOTAL_W-1:0]     tot_rd_data_a;
    logic [TOTAL_W-1:0]     tot_rd_data_b;

    logic                   stk_wr_en;
    logic [STK_ADDR_W-1:0]  stk_wr_addr;
    path_entry_t            stk_wr_data;
    logic                   stk_rd_en;
    logic [STK_ADDR_W-1:0]  stk_rd_addr;
    path_entry_t            stk_rd_data;

    // ---------------- datapath helpers ----------------
    logic                   cfg_wr;
    cfg_reg_t               cfg_sel;
    logic [DIM_W-1:0]       cfg_rows;
    logic [DIM_W-1:0]       cfg_cols;
    logic                   s_fire;
    logic                   out_free;
    logic [TOTAL_W-1:0]     up_val;
    logic [TOTAL_W-1:0]     left_val;
    logic [TOTAL_W-1:0]     nb_max;
    logic [SUM_W-1:0]       sum_wide;
    logic [TOTAL_W-1:0]     cell_total;
    logic                   last_cell;
    logic [TOTAL_W-1:0]     above_val;
    logic [TOTAL_W-1:0]     beside_val;
    logic                   go_up;
    logic [STK_CNT_W-1:0]   depth_dec;

    gmpst_total_ram #(
        .DEPTH  (TBL_DEPTH),
        .ADDR_W (TBL_ADDR_W)
    ) u_total_ram (
        .aclk      (aclk),
        .wr_en     (tot_wr_en),
        .wr_addr   (tot_wr_addr),
        .wr_data   (tot_wr_data),
        .rd_en     (tot_rd_en),
        .rd_addr_a (tot_rd_addr_a),
        .rd_addr_b (tot_rd_addr_b),
        .rd_data_a (tot_rd_data_a),
        .rd_data_b (tot_rd_data_b)
    );

    gmpst_stack_ram #(
        .DEPTH  (STK_DEPTH),
        .ADDR_W (STK_ADDR_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // ---------------- register port ----------------
    // Word address picks the register; sizes are clamped to 1..MAX on write.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[2]);

    always_comb begin
        if (pwdata == '0) begin
            cfg_rows = ONE_DIM;
        end else if (pwdata > APB_DATA_W'(MAX_ROWS)) begin
            cfg_rows = ROW_LIMIT;
        end else begin
            cfg_rows = pwdata[DIM_W-1:0];
        end
        if (pwdata == '0) begin
            cfg_cols = ONE_DIM;
        end else if (pwdata > APB_DATA_W'(MAX_COLUMNS)) begin
            cfg_cols = COL_LIMIT;
        end else begin
            cfg_cols = pwdata[DIM_W-1:0];
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ROW_COUNT:    prdata = APB_DATA_W'(rows_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(cols_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- cell datapath ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Neighbors outside the grid count as zero; left comes from the previous cell.
    assign up_val     = (cur_row_reg == ONE_DIM) ? '0 : tot_rd_data_a;
    assign left_val   = (cur_col_reg == ONE_DIM) ? '0 : left_reg;
    assign nb_max     = (up_val > left_val) ? up_val : left_val;
    assign sum_wide   = SUM_W'(value_reg) + SUM_W'(nb_max);
    assign cell_total = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    assign last_cell  = (cur_row_reg == rows_reg) && (cur_col_reg == cols_reg);

    // ---------------- trace decision ----------------
    assign above_val  = (tr_row_reg == ONE_DIM) ? '0 : tot_rd_data_a;
    assign beside_val = (tr_col_reg == ONE_DIM) ? '0 : tot_rd_data_b;

    always_comb begin
        priority if (here_reg == above_val) begin
            go_up = 1'b1;
        end else if (here_reg == beside_val) begin
            go_up = 1'b0;
        end else if (tr_row_reg == ONE_DIM) begin
            go_up = 1'b0;
        end else if (tr_col_reg == ONE_DIM) begin
            go_up = 1'b1;
        end else begin
            go_up = (above_val >= beside_val);
        end
    end

    assign depth_dec = depth_reg - STK_CNT_W'(1);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        depth_next     = depth_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        value_next     = value_reg;
        left_next      = left_reg;
        best_next      = best_reg;
        here_next      = here_reg;
        tr_row_next    = tr_row_reg;
        tr_col_next    = tr_col_reg;
        out_kind_next  = out_kind_reg;
        out_total_next = out_total_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        tot_wr_en      = 1'b0;
        tot_wr_addr    = cell_addr(cur_row_reg, cur_col_reg);
        tot_wr_data    = cell_total;
        tot_rd_en      = 1'b0;
        tot_rd_addr_a  = cell_addr(cur_row_reg - ONE_DIM, cur_col_reg);
        tot_rd_addr_b  = cell_addr(tr_row_reg, tr_col_reg - ONE_DIM);
        stk_wr_en      = 1'b0;
        stk_wr_addr    = depth_reg[STK_ADDR_W-1:0];
        stk_wr_data    = '{row: tr_row_reg, col: tr_col_reg};
        stk_rd_en      = 1'b0;
        stk_rd_addr    = depth_dec[STK_ADDR_W-1:0];

        // register writes restart the run; the user must write only while idle (the block does not enforce it)
        if (cfg_wr) begin
            cur_row_next = ONE_DIM;
            cur_col_next = ONE_DIM;
            unique case (cfg_sel)
                REG_ROW_COUNT:    rows_next = cfg_rows;
                REG_COLUMN_COUNT: cols_next = cfg_cols;
                default:          rows_next = rows_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                // fetch total above while latching the value
                if (s_fire) begin
                    tot_rd_en  = 1'b1;
                    value_next = s_tdata[VALUE_BITS-1:0];
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                tot_wr_en = 1'b1;
                left_next = cell_total;
                if (last_cell) begin
                    cur_row_next = ONE_DIM;
                    cur_col_next = ONE_DIM;
                    best_next    = cell_total;
                    here_next    = cell_total;
                    tr_row_next  = rows_reg;
                    tr_col_next  = cols_reg;
                    depth_next   = '0;
                    state_next   = S_TR_RD;
                end else begin
                    if (cur_col_reg == cols_reg) begin
                        cur_col_next = ONE_DIM;
                        cur_row_next = cur_row_reg + ONE_DIM;
                    end else begin
                        cur_col_next = cur_col_reg + ONE_DIM;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TR_RD: begin
                // read totals above and beside the trace position
                tot_rd_en     = 1'b1;
                tot_rd_addr_a = cell_addr(tr_row_reg - ONE_DIM, tr_col_reg);
                state_next    = S_TR_EV;
            end
            S_TR_EV: begin
                stk_wr_en  = 1'b1;
                depth_next = depth_reg + STK_CNT_W'(1);
                if (go_up) begin
                    here_next   = above_val;
                    tr_row_next = tr_row_reg - ONE_DIM;
                    state_next  = (tr_row_reg == ONE_DIM) ? S_TOTAL : S_TR_RD;
                end else begin
                    here_next   = beside_val;
                    tr_col_next = tr_col_reg - ONE_DIM;
                    state_next  = (tr_col_reg == ONE_DIM) ? S_TOTAL : S_TR_RD;
                end
            end
            S_TOTAL: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_kind_next  = KIND_TOTAL;
                    out_total_next = best_reg;
                    out_row_next   = '0;
                    out_col_next   = '0;
                    out_last_next  = 1'b0;
                    state_next     = S_POP_RD;
                end
            end
            S_POP_RD: begin
                stk_rd_en  = 1'b1;
                depth_next = depth_dec;
                state_next = S_POP_LD;
            end
            S_POP_LD: begin
                // stack data holds until the output slot frees
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_kind_next  = KIND_PATH;
                    out_total_next = '0;
                    out_row_next   = stk_rd_data.row;
                    out_col_next   = stk_rd_data.col;
                    out_last_next  = (depth_reg == '0);
                    state_next     = (depth_reg == '0) ? S_IDLE : S_POP_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rows_reg     <= ONE_DIM;
            cols_reg     <= ONE_DIM;
            cur_row_reg  <= ONE_DIM;
            cur_col_reg  <= ONE_DIM;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            depth_reg    <= depth_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        left_reg      <= left_next;
        best_reg      <= best_next;
        here_reg      <= here_next;
        tr_row_reg    <= tr_row_next;
        tr_col_reg    <= tr_col_next;
        out_kind_reg  <= out_kind_next;
        out_total_reg <= out_total_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    // ---------------- result channel ----------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_total_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
